// File: hdl/vps_pkg.sv
// Shared types, register codes, constants and saturation helpers of the particle step core.
package vps_pkg;

    // Handshake side band that travels with every pipeline stage
    typedef struct packed {
        logic vld;
        logic last;
    } side_t;

    // Register indexes on the configuration port (byte address = 4 * index)
    localparam logic [1:0] REG_STEP_TIME     = 2'd0;
    localparam logic [1:0] REG_WORLD_WIDTH   = 2'd1;
    localparam logic [1:0] REG_WORLD_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_BOUNCE_FACTOR = 2'd3;

    // Register reset values
    localparam logic [15:0] STEP_TIME_RST     = 16'd1092;
    localparam logic [30:0] WORLD_WIDTH_RST   = 31'd52428800;
    localparam logic [30:0] WORLD_HEIGHT_RST  = 31'd39321600;
    localparam logic [16:0] BOUNCE_FACTOR_RST = 17'd52429;

    // Drag coefficient 0.002 in Q0.32 and damping 0.998 in Q0.16
    localparam logic [23:0] DRAG_Q32 = 24'd8589935;
    localparam logic [15:0] DAMP_Q16 = 16'd65405;

    // Saturate a wide signed value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -66'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Apply a sign to an unsigned quotient and saturate to signed 32 bits
    function automatic logic signed [31:0] sat_quo(input logic [63:0] mag, input logic neg);
        logic signed [31:0] r;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                r = 32'sh8000_0000;
            end else begin
                r = 32'(64'd0 - mag);
            end
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                r = 32'sh7FFF_FFFF;
            end else begin
                r = mag[31:0];
            end
        end
        return r;
    endfunction

endpackage

// File: hdl/vps_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a tag that rides along.
module vps_div #(
    parameter int NW = 49,
    parameter int DW = 16,
    parameter int TW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [NW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);

    logic [NW-1:0] vld_reg;
    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] nq_reg   [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [TW-1:0] tag_reg  [NW];

    logic [DW-1:0] rem_in   [NW];
    logic [NW-1:0] nq_in    [NW];
    logic [DW-1:0] den_in   [NW];
    logic [TW-1:0] tag_in   [NW];
    logic [DW-1:0] rem_next [NW];
    logic [NW-1:0] nq_next  [NW];

    // One compare and subtract per stage; numerator bits shift out, quotient bits shift in
    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW:0] sh;
        logic [DW:0] diff;
        logic        ge;
        if (k == 0) begin : g_first
            assign rem_in[k] = '0;
            assign nq_in[k]  = i_num;
            assign den_in[k] = i_den;
            assign tag_in[k] = i_tag;
        end else begin : g_rest
            assign rem_in[k] = rem_reg[k-1];
            assign nq_in[k]  = nq_reg[k-1];
            assign den_in[k] = den_reg[k-1];
            assign tag_in[k] = tag_reg[k-1];
        end
        assign sh          = {rem_in[k], nq_in[k][NW-1]};
        assign diff        = sh - {1'b0, den_in[k]};
        assign ge          = (sh >= {1'b0, den_in[k]});
        assign rem_next[k] = ge ? diff[DW-1:0] : sh[DW-1:0];
        assign nq_next[k]  = {nq_in[k][NW-2:0], ge};
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NW-2:0], i_vld};
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NW; k++) begin
                rem_reg[k] <= rem_next[k];
                nq_reg[k]  <= nq_next[k];
                den_reg[k] <= den_in[k];
                tag_reg[k] <= tag_in[k];
            end
        end
    end

    assign o_vld = vld_reg[NW-1];
    assign o_quo = nq_reg[NW-1];
    assign o_tag = tag_reg[NW-1];

endmodule

// File: hdl/vps_axis.sv
// One axis of the particle step: drag, Verlet update, damping, wall bounce, previous position.
module vps_axis #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  vps_pkg::side_t      i_side,
    input  logic signed [31:0]  i_pos,
    input  logic signed [31:0]  i_prior,
    input  logic signed [31:0]  i_accel,
    input  logic [30:0]         i_mass,
    input  logic [30:0]         i_radius,
    input  logic [15:0]         step_time,
    input  logic [31:0]         dt_sq,
    input  logic [30:0]         world,
    input  logic [16:0]         bounce,
    output vps_pkg::side_t      o_side,
    output logic signed [31:0]  o_pos,
    output logic signed [31:0]  o_prior,
    output logic signed [31:0]  o_vel,
    output logic signed [31:0]  o_accel
);

    localparam int MASS_MIN = (1 << FRAC_BITS) / 10000;
    localparam int DRAG_SH  = 32 - FRAC_BITS;
    localparam int PW       = 56;
    localparam int N2W      = PW - DRAG_SH;
    localparam int N1W      = 49;

    typedef struct packed {
        logic               last;
        logic               neg;
        logic signed [31:0] pos;
        logic signed [31:0] prior;
        logic signed [31:0] accel;
        logic               heavy;
        logic [30:0]        mass;
        logic [30:0]        rad;
    } t1_t;

    typedef struct packed {
        logic               last;
        logic               neg;
        logic signed [31:0] pos;
        logic signed [31:0] prior;
        logic signed [31:0] accel;
        logic               heavy;
        logic [30:0]        rad;
    } t2_t;

    typedef struct packed {
        logic               last;
        logic signed [31:0] pos;
        logic signed [31:0] prior;
        logic signed [31:0] accel;
        logic [30:0]        rad;
    } t4_t;

    typedef struct packed {
        logic               last;
        logic               neg;
        logic signed [31:0] np;
        logic signed [31:0] accel;
        logic [30:0]        rad;
    } t3_t;

    typedef struct packed {
        logic               last;
        logic signed [31:0] np;
        logic signed [31:0] accel;
    } t11_t;

    // ---------------- stage 1: position difference
    logic               s1_vld_reg;
    t1_t                s1_tag_reg;
    logic signed [32:0] s1_d_reg;
    logic signed [32:0] s1_d_next;

    assign s1_d_next = 33'(i_pos) - 33'(i_prior);

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_d_reg         <= s1_d_next;
            s1_tag_reg.last  <= i_side.last;
            s1_tag_reg.neg   <= s1_d_next[32];
            s1_tag_reg.pos   <= i_pos;
            s1_tag_reg.prior <= i_prior;
            s1_tag_reg.accel <= i_accel;
            s1_tag_reg.heavy <= (i_mass > 31'(MASS_MIN));
            s1_tag_reg.mass  <= i_mass;
            s1_tag_reg.rad   <= i_radius;
        end
    end

    // ---------------- divide by dt for the drag velocity
    logic [32:0]    d1_mag;
    logic [N1W-1:0] d1_num;
    logic [15:0]    d1_den;
    logic           d1_vld;
    logic [N1W-1:0] d1_quo;
    t1_t            t1_out;

    assign d1_mag = s1_d_reg[32] ? 33'(-s1_d_reg) : 33'(s1_d_reg);
    assign d1_num = {d1_mag, 16'd0};
    // zero over zero yields zero; a nonzero value over zero saturates
    assign d1_den = (step_time == 16'd0 && s1_d_reg == 33'sd0) ? 16'd1 : step_time;

    vps_div #(.NW(N1W), .DW(16), .TW($bits(t1_t))) u_div_v (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .i_vld   (s1_vld_reg),
        .i_num   (d1_num),
        .i_den   (d1_den),
        .i_tag   (s1_tag_reg),
        .o_vld   (d1_vld),
        .o_quo   (d1_quo),
        .o_tag   (t1_out)
    );

    // ---------------- stage 2: signed velocity
    logic               s2_vld_reg;
    t1_t                s2_tag_reg;
    logic signed [31:0] s2_v_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_tag_reg <= t1_out;
            s2_v_reg   <= vps_pkg::sat_quo(64'(d1_quo), t1_out.neg);
        end
    end

    // ---------------- stage 3: drag numerator v * 0.002
    logic               s3_vld_reg;
    t1_t                s3_tag_reg;
    logic signed [PW-1:0] s3_prod_reg;
    logic signed [PW-1:0] s3_prod_next;

    assign s3_prod_next = s2_v_reg * $signed({1'b0, vps_pkg::DRAG_Q32});

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_tag_reg  <= s2_tag_reg;
            s3_prod_reg <= s3_prod_next;
        end
    end

    // ---------------- divide by mass (scale folded into a right shift)
    logic [PW-1:0]  d2_mag;
    logic [N2W-1:0] d2_num;
    t2_t            t2_in;
    logic           d2_vld;
    logic [N2W-1:0] d2_quo;
    t2_t            t2_out;

    assign d2_mag      = s3_prod_reg[PW-1] ? PW'(-s3_prod_reg) : PW'(s3_prod_reg);
    assign d2_num      = d2_mag[PW-1:DRAG_SH];
    assign t2_in.last  = s3_tag_reg.last;
    assign t2_in.neg   = s3_prod_reg[PW-1];
    assign t2_in.pos   = s3_tag_reg.pos;
    assign t2_in.prior = s3_tag_reg.prior;
    assign t2_in.accel = s3_tag_reg.accel;
    assign t2_in.heavy = s3_tag_reg.heavy;
    assign t2_in.rad   = s3_tag_reg.rad;

    vps_div #(.NW(N2W), .DW(31), .TW($bits(t2_t))) u_div_drag (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .i_vld   (s3_vld_reg),
        .i_num   (d2_num),
        .i_den   (s3_tag_reg.mass),
        .i_tag   (t2_in),
        .o_vld   (d2_vld),
        .o_quo   (d2_quo),
        .o_tag   (t2_out)
    );

    // ---------------- stage 4: acceleration with drag
    logic               s4_vld_reg;
    t4_t                s4_reg;
    logic signed [31:0] drag;
    logic signed [32:0] a_diff;
    logic signed [31:0] s4_accel_next;

    assign drag          = vps_pkg::sat_quo(64'(d2_quo), t2_out.neg);
    assign a_diff        = 33'(t2_out.accel) - 33'(drag);
    assign s4_accel_next = t2_out.heavy ? vps_pkg::sat32(66'(a_diff)) : t2_out.accel;

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_reg.last  <= t2_out.last;
            s4_reg.pos   <= t2_out.pos;
            s4_reg.prior <= t2_out.prior;
            s4_reg.accel <= s4_accel_next;
            s4_reg.rad   <= t2_out.rad;
        end
    end

    // ---------------- stage 5: a * dt * dt
    logic               s5_vld_reg;
    t4_t                s5_reg;
    logic signed [64:0] s5_prod_reg;
    logic signed [64:0] s5_prod_next;

    assign s5_prod_next = s4_reg.accel * $signed({1'b0, dt_sq});

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_reg      <= s4_reg;
            s5_prod_reg <= s5_prod_next;
        end
    end

    // ---------------- stage 6: scale down by 2^32 toward zero
    logic               s6_vld_reg;
    t4_t                s6_reg;
    logic signed [32:0] s6_t_reg;
    logic signed [64:0] s6_sum;

    assign s6_sum = s5_prod_reg + (s5_prod_reg[64] ? 65'sh0_FFFF_FFFF : 65'sd0);

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_reg   <= s5_reg;
            s6_t_reg <= s6_sum[64:32];
        end
    end

    // ---------------- stage 7: new position 2p - q + a dt^2
    logic               s7_vld_reg;
    t4_t                s7_reg;
    logic signed [31:0] s7_np_reg;
    logic signed [34:0] s7_sum;

    assign s7_sum = (35'(s6_reg.pos) <<< 1) - 35'(s6_reg.prior) + 35'(s6_t_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            s7_reg    <= s6_reg;
            s7_np_reg <= vps_pkg::sat32(66'(s7_sum));
        end
    end

    // ---------------- stage 8: displacement of this step
    logic               s8_vld_reg;
    t3_t                s8_tag_reg;
    logic signed [32:0] s8_d_reg;
    logic signed [32:0] s8_d_next;

    assign s8_d_next = 33'(s7_np_reg) - 33'(s7_reg.pos);

    always_ff @(posedge aclk) begin
        if (en) begin
            s8_d_reg         <= s8_d_next;
            s8_tag_reg.last  <= s7_reg.last;
            s8_tag_reg.neg   <= s8_d_next[32];
            s8_tag_reg.np    <= s7_np_reg;
            s8_tag_reg.accel <= s7_reg.accel;
            s8_tag_reg.rad   <= s7_reg.rad;
        end
    end

    // ---------------- divide by dt for the new velocity
    logic [32:0]    d3_mag;
    logic [N1W-1:0] d3_num;
    logic [15:0]    d3_den;
    logic           d3_vld;
    logic [N1W-1:0] d3_quo;
    t3_t            t3_out;

    assign d3_mag = s8_d_reg[32] ? 33'(-s8_d_reg) : 33'(s8_d_reg);
    assign d3_num = {d3_mag, 16'd0};
    assign d3_den = (step_time == 16'd0 && s8_d_reg == 33'sd0) ? 16'd1 : step_time;

    vps_div #(.NW(N1W), .DW(16), .TW($bits(t3_t))) u_div_vel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .i_vld   (s8_vld_reg),
        .i_num   (d3_num),
        .i_den   (d3_den),
        .i_tag   (s8_tag_reg),
        .o_vld   (d3_vld),
        .o_quo   (d3_quo),
        .o_tag   (t3_out)
    );

    // ---------------- stage 9: signed velocity
    logic               s9_vld_reg;
    t3_t                s9_tag_reg;
    logic signed [31:0] s9_vel_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s9_tag_reg <= t3_out;
            s9_vel_reg <= vps_pkg::sat_quo(64'(d3_quo), t3_out.neg);
        end
    end

    // ---------------- stage 10: damping product
    logic               s10_vld_reg;
    t3_t                s10_tag_reg;
    logic signed [48:0] s10_prod_reg;
    logic signed [48:0] s10_prod_next;

    assign s10_prod_next = s9_vel_reg * $signed({1'b0, vps_pkg::DAMP_Q16});

    always_ff @(posedge aclk) begin
        if (en) begin
            s10_tag_reg  <= s9_tag_reg;
            s10_prod_reg <= s10_prod_next;
        end
    end

    // ---------------- stage 11: damped velocity and wall test
    logic               s11_vld_reg;
    t11_t               s11_reg;
    logic signed [31:0] s11_vd_reg;
    logic               s11_hit_reg;
    logic signed [48:0] s11_sum;
    logic signed [31:0] rad_s;
    logic signed [31:0] high_wall;
    logic               hit_low;
    logic               hit_high;

    assign s11_sum   = s10_prod_reg + (s10_prod_reg[48] ? 49'sh0_FFFF : 49'sd0);
    assign rad_s     = $signed({1'b0, s10_tag_reg.rad});
    assign high_wall = $signed({1'b0, world}) - rad_s;
    // low wall wins when both walls are crossed
    assign hit_low   = (s10_tag_reg.np < rad_s);
    assign hit_high  = (s10_tag_reg.np > high_wall);

    always_ff @(posedge aclk) begin
        if (en) begin
            s11_reg.last  <= s10_tag_reg.last;
            s11_reg.accel <= s10_tag_reg.accel;
            s11_reg.np    <= hit_low ? rad_s : (hit_high ? high_wall : s10_tag_reg.np);
            s11_vd_reg    <= s11_sum[47:16];
            s11_hit_reg   <= hit_low | hit_high;
        end
    end

    // ---------------- stage 12: restitution product
    logic               s12_vld_reg;
    t11_t               s12_reg;
    logic signed [31:0] s12_vd_reg;
    logic               s12_hit_reg;
    logic signed [49:0] s12_prod_reg;
    logic signed [49:0] s12_prod_next;

    assign s12_prod_next = s11_vd_reg * $signed({1'b0, bounce});

    always_ff @(posedge aclk) begin
        if (en) begin
            s12_reg      <= s11_reg;
            s12_vd_reg   <= s11_vd_reg;
            s12_hit_reg  <= s11_hit_reg;
            s12_prod_reg <= s12_prod_next;
        end
    end

    // ---------------- stage 13: reflect velocity on a wall hit
    logic               s13_vld_reg;
    t11_t               s13_reg;
    logic signed [31:0] s13_vel_reg;
    logic signed [49:0] s13_sum;
    logic signed [34:0] s13_neg;

    assign s13_sum = s12_prod_reg + (s12_prod_reg[49] ? 50'sh0_FFFF : 50'sd0);
    assign s13_neg = 35'sd0 - 35'($signed(s13_sum[49:16]));

    always_ff @(posedge aclk) begin
        if (en) begin
            s13_reg     <= s12_reg;
            s13_vel_reg <= s12_hit_reg ? vps_pkg::sat32(66'(s13_neg)) : s12_vd_reg;
        end
    end

    // ---------------- stage 14: v * dt for the previous position
    logic               s14_vld_reg;
    t11_t               s14_reg;
    logic signed [31:0] s14_vel_reg;
    logic signed [48:0] s14_prod_reg;
    logic signed [48:0] s14_prod_next;

    assign s14_prod_next = s13_vel_reg * $signed({1'b0, step_time});

    always_ff @(posedge aclk) begin
        if (en) begin
            s14_reg      <= s13_reg;
            s14_vel_reg  <= s13_vel_reg;
            s14_prod_reg <= s14_prod_next;
        end
    end

    // ---------------- stage 15: previous position, output register
    logic               s15_last_reg;
    logic signed [31:0] s15_pos_reg;
    logic signed [31:0] s15_prior_reg;
    logic signed [31:0] s15_vel_reg;
    logic signed [31:0] s15_accel_reg;
    logic signed [48:0] s15_sum;
    logic signed [33:0] s15_nq;
    logic               s15_vld_reg;

    assign s15_sum = s14_prod_reg + (s14_prod_reg[48] ? 49'sh0_FFFF : 49'sd0);
    assign s15_nq  = 34'(s14_reg.np) - 34'($signed(s15_sum[48:16]));

    always_ff @(posedge aclk) begin
        if (en) begin
            s15_last_reg  <= s14_reg.last;
            s15_pos_reg   <= s14_reg.np;
            s15_prior_reg <= vps_pkg::sat32(66'(s15_nq));
            s15_vel_reg   <= s14_vel_reg;
            s15_accel_reg <= s14_reg.accel;
        end
    end

    // Advance valid bits of the plain stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            s12_vld_reg <= 1'b0;
            s13_vld_reg <= 1'b0;
            s14_vld_reg <= 1'b0;
            s15_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg  <= i_side.vld;
            s2_vld_reg  <= d1_vld;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= d2_vld;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= d3_vld;
            s10_vld_reg <= s9_vld_reg;
            s11_vld_reg <= s10_vld_reg;
            s12_vld_reg <= s11_vld_reg;
            s13_vld_reg <= s12_vld_reg;
            s14_vld_reg <= s13_vld_reg;
            s15_vld_reg <= s14_vld_reg;
        end
    end

    assign o_side.vld  = s15_vld_reg;
    assign o_side.last = s15_last_reg;
    assign o_pos       = s15_pos_reg;
    assign o_prior     = s15_prior_reg;
    assign o_vel       = s15_vel_reg;
    assign o_accel     = s15_accel_reg;

endmodule

// File: hdl/verlet_particle_step_core.sv
// Top level of the Verlet particle step core: configuration registers and two axis pipelines.
// One particle enters per clock while the pipeline is not stalled. Each axis holds three
// bit-serial pipelined dividers: two of 49 stages for the divisions by the step time and
// one of 24 + FRAC_BITS stages for the division by mass. The whole pipeline advances
// together; it stalls only while a result waits at the output and m_tready is low.
// Configuration must be written while no particle is in flight.
module verlet_particle_step_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, prior_x, prior_y, accel_x, accel_y (32 each), particle_mass (31),
    // particle_radius (31), two zero bits
    input  logic [255:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_pos_x, new_pos_y, new_prior_x, new_prior_y, vel_x, vel_y, new_accel_x,
    // new_accel_y (32 each)
    output logic [255:0] m_tdata,
    output logic         m_tlast
);

    logic [15:0] step_time_reg;
    logic [30:0] world_width_reg;
    logic [30:0] world_height_reg;
    logic [16:0] bounce_factor_reg;
    logic [31:0] dt_sq_reg;
    logic        cfg_wr;

    // Register writes
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg     <= vps_pkg::STEP_TIME_RST;
            world_width_reg   <= vps_pkg::WORLD_WIDTH_RST;
            world_height_reg  <= vps_pkg::WORLD_HEIGHT_RST;
            bounce_factor_reg <= vps_pkg::BOUNCE_FACTOR_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                vps_pkg::REG_STEP_TIME:     step_time_reg     <= pwdata[15:0];
                vps_pkg::REG_WORLD_WIDTH:   world_width_reg   <= pwdata[30:0];
                vps_pkg::REG_WORLD_HEIGHT:  world_height_reg  <= pwdata[30:0];
                vps_pkg::REG_BOUNCE_FACTOR: bounce_factor_reg <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[3:2])
            vps_pkg::REG_STEP_TIME:     prdata = 32'(step_time_reg);
            vps_pkg::REG_WORLD_WIDTH:   prdata = 32'(world_width_reg);
            vps_pkg::REG_WORLD_HEIGHT:  prdata = 32'(world_height_reg);
            vps_pkg::REG_BOUNCE_FACTOR: prdata = 32'(bounce_factor_reg);
            default:                    prdata = 32'd0;
        endcase
    end

    // Hold dt squared; it follows the step time in the cycle after a write
    always_ff @(posedge aclk) begin
        dt_sq_reg <= step_time_reg * step_time_reg;
    end

    // Global advance: move when the output register is empty or being drained
    vps_pkg::side_t in_side;
    vps_pkg::side_t x_side;
    vps_pkg::side_t y_side;
    logic           en;

    assign en           = !x_side.vld || m_tready;
    assign s_tready     = en & aresetn;
    assign in_side.vld  = s_tvalid;
    assign in_side.last = s_tlast;

    vps_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .i_side    (in_side),
        .i_pos     ($signed(s_tdata[31:0])),
        .i_prior   ($signed(s_tdata[95:64])),
        .i_accel   ($signed(s_tdata[159:128])),
        .i_mass    (s_tdata[222:192]),
        .i_radius  (s_tdata[253:223]),
        .step_time (step_time_reg),
        .dt_sq     (dt_sq_reg),
        .world     (world_width_reg),
        .bounce    (bounce_factor_reg),
        .o_side    (x_side),
        .o_pos     (m_tdata[31:0]),
        .o_prior   (m_tdata[95:64]),
        .o_vel     (m_tdata[159:128]),
        .o_accel   (m_tdata[223:192])
    );

    vps_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .i_side    (in_side),
        .i_pos     ($signed(s_tdata[63:32])),
        .i_prior   ($signed(s_tdata[127:96])),
        .i_accel   ($signed(s_tdata[191:160])),
        .i_mass    (s_tdata[222:192]),
        .i_radius  (s_tdata[253:223]),
        .step_time (step_time_reg),
        .dt_sq     (dt_sq_reg),
        .world     (world_height_reg),
        .bounce    (bounce_factor_reg),
        .o_side    (y_side),
        .o_pos     (m_tdata[63:32]),
        .o_prior   (m_tdata[127:96]),
        .o_vel     (m_tdata[191:160]),
        .o_accel   (m_tdata[255:224])
    );

    // Both axes run in lock step
    assign m_tvalid = x_side.vld & y_side.vld;
    assign m_tlast  = x_side.last & y_side.last;

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the Verlet particle step core: directed table, then random particles.
`timescale 1ns / 1ps

module testbench;

    localparam longint MAX32    = 64'sd2147483647;
    localparam longint MIN32    = -64'sd2147483648;
    localparam longint MASS_MIN = 6;
    localparam int     WDOG_MAX = 5000;
    localparam int     TAIL     = 220;

    typedef struct {
        logic signed [31:0] px, py, qx, qy, ax, ay;
        logic [30:0]        mass, rad;
        logic               last;
    } particle_t;

    typedef struct {
        logic [31:0] f [8];
        logic        last;
    } step_out_t;

    typedef struct {
        particle_t p;
        logic      typed;
        step_out_t want;
    } row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // pos_x, pos_y, prior_x, prior_y, accel_x, accel_y, particle_mass, particle_radius
    logic [255:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // new_pos_x, new_pos_y, new_prior_x, new_prior_y, vel_x, vel_y, new_accel_x, new_accel_y
    logic [255:0] m_tdata;
    logic         m_tlast;

    verlet_particle_step_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow copy of the configuration registers
    longint    dt_q16   = vps_pkg::STEP_TIME_RST;
    longint    world_w  = vps_pkg::WORLD_WIDTH_RST;
    longint    world_h  = vps_pkg::WORLD_HEIGHT_RST;
    longint    bounce   = vps_pkg::BOUNCE_FACTOR_RST;

    step_out_t pending_steps [$];
    int        errors = 0;
    int        idle_cycles = 0;
    int        gap_max = 8;
    int        rx_stall = 0;
    row_t      rows [$];

    function automatic longint clip32(longint v);
        if (v > MAX32) return MAX32;
        if (v < MIN32) return MIN32;
        return v;
    endfunction

    // Divide a Q16.16 difference by the Q0.16 step time
    function automatic longint per_dt(longint d, longint dt);
        if (dt == 0) return d > 0 ? MAX32 : (d < 0 ? MIN32 : 0);
        return clip32((d * 65536) / dt);
    endfunction

    function automatic longint rewind(longint p, longint v, longint dt);
        return clip32(p - (v * dt) / 65536);
    endfunction

    // One axis of the particle step
    function automatic void step_axis(input longint p, q, a, mass, r, world,
                                      output logic [31:0] o_pos, o_prior, o_vel, o_acc);
        longint v, drag, np, vel, nq;
        if (mass > MASS_MIN) begin
            v    = per_dt(p - q, dt_q16);
            drag = clip32((v * longint'(vps_pkg::DRAG_Q32)) / (mass * 65536));
            a    = clip32(a - drag);
        end
        np  = clip32(2 * p - q + (a * (dt_q16 * dt_q16)) / 64'sd4294967296);
        vel = per_dt(np - p, dt_q16);
        vel = (vel * longint'(vps_pkg::DAMP_Q16)) / 65536;
        nq  = rewind(np, vel, dt_q16);
        if (np < r) begin
            np  = r;
            vel = clip32(-(vel * bounce) / 65536);
            nq  = rewind(np, vel, dt_q16);
        end else if (np > world - r) begin
            np  = clip32(world - r);
            vel = clip32(-(vel * bounce) / 65536);
            nq  = rewind(np, vel, dt_q16);
        end
        o_pos   = np[31:0];
        o_prior = nq[31:0];
        o_vel   = vel[31:0];
        o_acc   = a[31:0];
    endfunction

    function automatic step_out_t predict_step(particle_t p);
        step_out_t o;
        step_axis(p.px, p.qx, p.ax, p.mass, p.rad, world_w, o.f[0], o.f[2], o.f[4], o.f[6]);
        step_axis(p.py, p.qy, p.ay, p.mass, p.rad, world_h, o.f[1], o.f[3], o.f[5], o.f[7]);
        o.last = p.last;
        return o;
    endfunction

    function automatic particle_t mk(longint px, py, qx, qy, ax, ay, mass, rad, logic last);
        particle_t p;
        p.px = px[31:0]; p.py = py[31:0]; p.qx = qx[31:0]; p.qy = qy[31:0];
        p.ax = ax[31:0]; p.ay = ay[31:0];
        p.mass = mass[30:0]; p.rad = rad[30:0]; p.last = last;
        return p;
    endfunction

    function automatic particle_t rand_particle();
        particle_t p;
        longint    span;
        if ($urandom_range(0, 9) < 7) begin
            // plausible particle inside the world, moving slowly
            span   = (world_w > 0) ? world_w : 1;
            p.px   = 32'($urandom_range(0, 32'(span)));
            span   = (world_h > 0) ? world_h : 1;
            p.py   = 32'($urandom_range(0, 32'(span)));
            p.qx   = p.px + 32'(int'($urandom_range(0, 8000)) - 4000);
            p.qy   = p.py + 32'(int'($urandom_range(0, 8000)) - 4000);
            p.ax   = 32'(int'($urandom_range(0, 32'd20000000)) - 10000000);
            p.ay   = 32'(int'($urandom_range(0, 32'd20000000)) - 10000000);
            p.mass = 31'($urandom_range(0, 32'd13107200));
            p.rad  = 31'($urandom_range(0, 32'd1310720));
        end else begin
            p.px = $urandom; p.py = $urandom; p.qx = $urandom; p.qy = $urandom;
            p.ax = $urandom; p.ay = $urandom;
            p.mass = $urandom_range(0, 3) == 0 ? 31'($urandom_range(0, 12)) : 31'($urandom);
            p.rad  = $urandom_range(0, 1) == 0 ? 31'($urandom_range(0, 100000)) : 31'($urandom);
        end
        p.last = 1'($urandom_range(0, 1));
        return p;
    endfunction

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            vps_pkg::REG_STEP_TIME:     dt_q16  = value[15:0];
            vps_pkg::REG_WORLD_WIDTH:   world_w = value[30:0];
            vps_pkg::REG_WORLD_HEIGHT:  world_h = value[30:0];
            vps_pkg::REG_BOUNCE_FACTOR: bounce  = value[16:0];
            default: ;
        endcase
    endtask

    task automatic set_config(longint dt, ww, wh, bf);
        reg_write(vps_pkg::REG_STEP_TIME, 32'(dt));
        reg_write(vps_pkg::REG_WORLD_WIDTH, 32'(ww));
        reg_write(vps_pkg::REG_WORLD_HEIGHT, 32'(wh));
        reg_write(vps_pkg::REG_BOUNCE_FACTOR, 32'(bf));
    endtask

    // Offer one particle and hold it until the transfer happens
    task automatic send(particle_t p, step_out_t want);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tlast  <= p.last;
        s_tdata  <= {2'b00, p.rad, p.mass, p.ay, p.ax, p.qy, p.qx, p.py, p.px};
        do @(posedge aclk); while (!s_tready);
        pending_steps.push_back(want);
    endtask

    // Wait for every expected result, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge aclk);
        repeat (TAIL) @(posedge aclk);
    endtask

    task automatic random_items(int n);
        particle_t p;
        for (int i = 0; i < n; i++) begin
            p = rand_particle();
            send(p, predict_step(p));
        end
    endtask

    // Check each result transfer and draw the receiver stalls
    always @(posedge aclk) begin
        step_out_t want;
        logic      nxt;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_steps.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = pending_steps.pop_front();
                    for (int k = 0; k < 8; k++) begin
                        if (m_tdata[32*k +: 32] !== want.f[k]) begin
                            $display("%0t field %0d: expected %h, actual %h",
                                     $time, k, want.f[k], m_tdata[32*k +: 32]);
                            errors++;
                        end
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t last: expected %b, actual %b", $time, want.last, m_tlast);
                        errors++;
                    end
                end
                rx_stall = $urandom_range(0, gap_max);
            end
            nxt = 1'b1;
            if (rx_stall > 0) begin
                nxt = 1'b0;
                rx_stall--;
            end
            m_tready <= nxt;
        end
    end

    // Stop the run when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WDOG_MAX) begin
            $display("verlet_particle_step_core: mismatch");
            $finish;
        end
    end

    initial begin
        row_t r;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows; the first two have results that are obvious by hand
        r.typed = 1'b1;
        r.p = mk(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        foreach (r.want.f[k]) r.want.f[k] = '0;
        r.want.last = 1'b0;
        rows.push_back(r);
        r.p = mk(0, 0, 0, 0, 0, 0, 0, 100 * 65536, 1'b1);
        r.want.f = '{32'd6553600, 32'd6553600, 32'd6553600, 32'd6553600, 0, 0, 0, 0};
        r.want.last = 1'b1;
        rows.push_back(r);
        r.typed = 1'b0;
        r.p = mk(MAX32, MAX32, MIN32, MIN32, MAX32, MAX32, 31'h7FFF_FFFF, 0, 1'b0);
        rows.push_back(r);
        r.p = mk(MIN32, MIN32, MAX32, MAX32, MIN32, MIN32, 7, 0, 1'b1);
        rows.push_back(r);
        r.p = mk(65536 * 10, 65536 * 10, 65536 * 9, 65536 * 11, 0, 0, 6, 0, 1'b0);
        rows.push_back(r);
        r.p = mk(65536 * 10, 65536 * 10, 65536 * 9, 65536 * 11, 0, 0, 7, 0, 1'b0);
        rows.push_back(r);
        r.p = mk(65536 * 10, 65536 * 10, 65536 * 9, 65536 * 11, MIN32, MAX32,
                 65536, 65536, 1'b0);
        rows.push_back(r);
        r.p = mk(65536 * 700, 65536 * 500, 65536 * 690, 65536 * 590, 0, 0, 65536, 65536, 1'b0);
        rows.push_back(r);
        r.p = mk(65536 * 5, 65536 * 5, 65536 * 5, 65536 * 5, 0, 0, 0, 31'h7FFF_FFFF, 1'b1);
        rows.push_back(r);
        r.p = mk(-65536, -65536, 65536, 65536, 65536 * 9, -65536 * 9, 65536 * 2, 65536, 1'b0);
        rows.push_back(r);
        r.p = mk(1, -1, -1, 1, 1, -1, 0, 1, 1'b1);
        rows.push_back(r);
        r.p = mk(MAX32, MIN32, MAX32, MIN32, 0, 0, 31'h7FFF_FFFF, 31'h4000_0000, 1'b0);
        rows.push_back(r);
        foreach (rows[i]) send(rows[i].p, rows[i].typed ? rows[i].want : predict_step(rows[i].p));

        // Reset configuration, random particles, with a full pause midway
        random_items(150);
        drain();
        random_items(150);
        drain();

        // Shortest step, empty width, widest height, no bounce; no idling
        gap_max = 0;
        set_config(1, 0, 32'h7FFF_FFFF, 0);
        random_items(300);
        drain();

        // Longest step, widest width, empty height, full bounce
        gap_max = 8;
        set_config(65535, 32'h7FFF_FFFF, 0, 65536);
        random_items(300);
        drain();

        // Random mid-range setting
        set_config($urandom_range(1, 65535), $urandom_range(65536, 32'h7FFF_FFFF),
                   $urandom_range(65536, 32'h7FFF_FFFF), $urandom_range(0, 65536));
        random_items(300);
        drain();

        // Back to a typical setting with a full bounce
        set_config(1092, 52428800, 39321600, 65536);
        random_items(330);
        drain();

        if (errors == 0) begin
            $display("verlet_particle_step_core: match");
        end else begin
            $display("verlet_particle_step_core: mismatch");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/vps_pkg.sv
hdl/vps_div.sv
hdl/vps_axis.sv
hdl/verlet_particle_step_core.sv
sim/testbench.sv
